[hdl/huffman_code_packer_macros.svh]
// Assertion macros shared by the Huffman code packer RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef HUFFMAN_CODE_PACKER_MACROS_SVH
`define HUFFMAN_CODE_PACKER_MACROS_SVH

// same-cycle implication, checked out of reset
`define HPK_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define HPK_ASSERT_NXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[hdl/hpk_pkg.sv]
// Package of the Huffman code packer: operation codes, stream widths,
// queue status type and the byte mask helper. No dependencies.
package hpk_pkg;

    // operation carried in s_tuser
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_END    = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    localparam int BYTE_BITS = 8;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;
    localparam int Q_DEPTH   = 2;
    localparam logic [15:0] TOTAL_MAX = 16'hFFFF;

    // job queue status seen by front and back
    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

    // mask of the n low bits of a byte, n in 0..8
    function automatic logic [7:0] low_mask(input logic [3:0] n);
        logic [7:0] m;
        m = (n == 4'd0) ? 8'h00 : (8'hFF >> (4'd8 - n));
        return m;
    endfunction

endpackage

[hdl/hpk_queue.sv]
// Two-entry job queue between the front and back of the code packer.
// Depends on hpk_pkg and huffman_code_packer_macros.svh.
`include "huffman_code_packer_macros.svh"

module hpk_queue #(
    parameter int DATA_W = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [DATA_W-1:0]   push_data,
    input  logic                pop,
    output logic [DATA_W-1:0]   pop_data,
    output hpk_pkg::q_status_t  status
);
    import hpk_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    logic [DATA_W-1:0] slot_reg [Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W:0]    count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign pop_data         = slot_reg[rd_ptr_reg];
    assign status.not_empty = (count_reg != '0);
    assign status.full      = (count_reg == (PTR_W + 1)'(Q_DEPTH));

    `HPK_ASSERT_IMP(a_no_overflow, push, !status.full, "job queue written while full")
    `HPK_ASSERT_IMP(a_no_underflow, pop, status.not_empty, "job queue read while empty")

endmodule

[hdl/hpk_front.sv]
// Front of the code packer: takes words, writes the code table on loads,
// looks up codes on encodes and hands end jobs and encodes of used symbols to the queue.
// Depends on hpk_pkg.
module hpk_front #(
    parameter int SYMBOL_COUNT  = 128,
    parameter int MAX_CODE_BITS = 32,
    parameter int LEN_W         = 6,
    parameter int JOB_W         = 39
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [1:0]          operation,
    input  logic [6:0]          symbol,
    input  logic [31:0]         code_value,
    input  logic [5:0]          code_length,
    input  hpk_pkg::q_status_t  q_stat,
    output logic                push,
    output logic [JOB_W-1:0]    job
);
    import hpk_pkg::*;

    localparam int SYM_W = $clog2(SYMBOL_COUNT);

    op_t                      op;
    logic [8:0]               sym_wide;
    logic                     in_range;
    logic [SYM_W-1:0]         idx;
    logic                     accept;
    logic [LEN_W-1:0]         len_clamped;
    logic [MAX_CODE_BITS-1:0] code_masked;
    logic                     wr_en;

    // table storage, code store has no reset
    logic [MAX_CODE_BITS-1:0] code_mem [SYMBOL_COUNT];
    logic [LEN_W-1:0]         len_mem  [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0]  len_valid_reg;

    // lookup stage
    logic                     s1_valid_reg;
    logic                     s1_end_reg;
    logic [MAX_CODE_BITS-1:0] code_rd_reg;
    logic [LEN_W-1:0]         len_rd_reg;
    logic                     vld_rd_reg;
    logic [LEN_W-1:0]         s1_len;
    logic                     s1_keep;
    logic                     s1_adv;

    // decode the incoming word
    assign op       = op_t'(operation);
    assign sym_wide = {2'b00, symbol};
    assign in_range = (sym_wide < 9'(SYMBOL_COUNT));
    assign idx      = sym_wide[SYM_W-1:0];
    assign accept   = s_tvalid && s_tready;
    assign wr_en    = accept && (op == OP_LOAD) && in_range;

    // clamp the length, drop code bits above it
    assign len_clamped = (code_length > 6'(MAX_CODE_BITS)) ? LEN_W'(MAX_CODE_BITS)
                                                            : LEN_W'(code_length);
    assign code_masked = code_value[MAX_CODE_BITS-1:0]
                       & ~({MAX_CODE_BITS{1'b1}} << len_clamped);

    // table write and registered lookup
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            code_mem[idx] <= code_masked;
            len_mem[idx]  <= len_clamped;
        end
        if (accept)
        begin
            code_rd_reg <= code_mem[idx];
            len_rd_reg  <= len_mem[idx];
            vld_rd_reg  <= len_valid_reg[idx];
        end
    end

    // length valid bits, an unwritten entry reads as length zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            len_valid_reg[idx] <= 1'b1;
        end
    end

    // lookup stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_end_reg   <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= accept && ((op == OP_END) || ((op == OP_ENCODE) && in_range));
            s1_end_reg   <= (op == OP_END);
        end
    end

    // unused symbols are dropped here, everything else goes to the queue
    assign s1_len   = vld_rd_reg ? len_rd_reg : '0;
    assign s1_keep  = s1_end_reg || (s1_len != '0);
    assign s1_adv   = s1_valid_reg && (!s1_keep || !q_stat.full);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign push     = s1_valid_reg && s1_keep && !q_stat.full;
    assign job      = {s1_end_reg, s1_len, code_rd_reg};

endmodule

[hdl/hpk_back.sv]
// Back of the code packer: bit accumulator, byte emitter, bit total and
// output register. Depends on hpk_pkg and huffman_code_packer_macros.svh.
`include "huffman_code_packer_macros.svh"

module hpk_back #(
    parameter int MAX_CODE_BITS = 32,
    parameter int LEN_W         = 6,
    parameter int JOB_W         = 39
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  hpk_pkg::q_status_t           q_stat,
    input  logic [JOB_W-1:0]             job,
    output logic                         pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [hpk_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                         m_tuser,
    output logic                         m_tlast
);
    import hpk_pkg::*;

    localparam int ACC_W = MAX_CODE_BITS + 7;
    localparam int CNT_W = $clog2(ACC_W + 1);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t                   state_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [6:0]               pend_bits_reg;
    logic [2:0]               pend_cnt_reg;
    logic [15:0]              total_reg;
    logic                     out_valid_reg;
    logic [7:0]               out_byte_reg;
    logic [15:0]              out_total_reg;
    logic                     out_data_reg;
    logic                     out_last_reg;

    logic                     job_end;
    logic [LEN_W-1:0]         job_len;
    logic [MAX_CODE_BITS-1:0] job_code;
    logic                     out_free;
    logic                     out_load;
    logic [ACC_W-1:0]         acc_load;
    logic [CNT_W-1:0]         cnt_load;
    logic [16:0]              total_sum;
    logic [15:0]              total_load;
    logic [7:0]               emit_byte;
    logic [CNT_W-1:0]         cnt_after;
    logic [7:0]               end_byte;

    assign {job_end, job_len, job_code} = job;
    assign out_free = !out_valid_reg || m_tready;

    // append the code under the pending bits
    assign acc_load   = (ACC_W'(pend_bits_reg) << job_len) | ACC_W'(job_code);
    assign cnt_load   = CNT_W'(pend_cnt_reg) + CNT_W'(job_len);
    assign total_sum  = {1'b0, total_reg} + 17'(job_len);
    assign total_load = total_sum[16] ? TOTAL_MAX : total_sum[15:0];

    // next byte from the top of the accumulated bits
    assign cnt_after = cnt_reg - CNT_W'(BYTE_BITS);
    assign emit_byte = 8'(acc_reg >> cnt_after);

    // final partial byte, left aligned and zero padded
    assign end_byte = 8'({1'b0, pend_bits_reg} << (4'(BYTE_BITS) - {1'b0, pend_cnt_reg}));

    assign pop = (state_reg == ST_IDLE) && q_stat.not_empty && (!job_end || out_free);

    // a new output word this cycle, from an end job or the emitter
    assign out_load = (pop && job_end) || ((state_reg == ST_EMIT) && out_free);

    // sequencer, accumulator and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_total_reg <= '0;
            out_data_reg  <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            // output word: a new word replaces a taken one
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop && job_end)
                    begin
                        out_byte_reg  <= (pend_cnt_reg != 3'd0) ? end_byte : 8'h00;
                        out_data_reg  <= (pend_cnt_reg != 3'd0);
                        out_total_reg <= total_reg;
                        out_last_reg  <= 1'b1;
                        pend_bits_reg <= '0;
                        pend_cnt_reg  <= '0;
                        total_reg     <= '0;
                    end
                    else if (pop)
                    begin
                        total_reg <= total_load;
                        acc_reg   <= acc_load;
                        cnt_reg   <= cnt_load;
                        if (cnt_load >= CNT_W'(BYTE_BITS))
                        begin
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            pend_bits_reg <= acc_load[6:0] & 7'(low_mask(4'(cnt_load)));
                            pend_cnt_reg  <= 3'(cnt_load);
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_byte_reg  <= emit_byte;
                        out_data_reg  <= 1'b1;
                        out_total_reg <= total_reg;
                        out_last_reg  <= 1'b0;
                        cnt_reg       <= cnt_after;
                        if (cnt_after < CNT_W'(BYTE_BITS))
                        begin
                            pend_bits_reg <= acc_reg[6:0] & 7'(low_mask(4'(cnt_after)));
                            pend_cnt_reg  <= 3'(cnt_after);
                            state_reg     <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_total_reg, out_byte_reg};
    assign m_tuser  = out_data_reg;
    assign m_tlast  = out_last_reg;

    `HPK_ASSERT_IMP(a_emit_has_byte, state_reg == ST_EMIT,
        cnt_reg >= CNT_W'(BYTE_BITS), "emitting with less than a byte")
    `HPK_ASSERT_IMP(a_empty_end_zero, m_tvalid && m_tlast && !m_tuser,
        m_tdata[7:0] == 8'h00, "empty end word carries bits")
    `HPK_ASSERT_NXT(a_end_clears, pop && job_end,
        pend_cnt_reg == 3'd0 && total_reg == 16'h0000, "end did not clear the accumulator")

endmodule

[hdl/huffman_code_packer.sv]
// Top level of the Huffman code packer: front (table and lookup),
// job queue and back (bit packing). Depends on hpk_pkg and the hpk_* modules.
//
//  channel | direction | tdata (low bit up)                            | tuser        | tlast
//  s_*     | in        | symbol[6:0] code_value[38:7] code_length[44:39] | operation    | -
//  m_*     | out       | data_byte[7:0] total_bits[23:8]               | byte_is_data | last
//
// A load ends in the front; the back pops an end word into the output register and an
// encode word into the accumulator, then emits the k = 0..4 bytes it completes, one
// byte a cycle while the output is free. The front registers each table read, then queues it.
// Reset clears the length table valid bits at once; no clearing pass is needed.
// A two-entry queue and the output register let either side stall independently.
module huffman_code_packer #(
    parameter int SYMBOL_COUNT  = 128,
    parameter int MAX_CODE_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // symbol[6:0], code_value[38:7], code_length[44:39], zero fill [47:45]
    input  logic [hpk_pkg::S_TDATA_W-1:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // data_byte[7:0], total_bits[23:8]
    output logic [hpk_pkg::M_TDATA_W-1:0] m_tdata,
    // byte_is_data[0]
    output logic                          m_tuser,
    output logic                          m_tlast
);
    import hpk_pkg::*;

    localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);
    localparam int JOB_W = 1 + LEN_W + MAX_CODE_BITS;

    q_status_t        q_stat;
    logic             q_push;
    logic             q_pop;
    logic [JOB_W-1:0] q_in;
    logic [JOB_W-1:0] q_out;

    hpk_front #(
        .SYMBOL_COUNT  (SYMBOL_COUNT),
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .LEN_W         (LEN_W),
        .JOB_W         (JOB_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .operation   (s_tuser),
        .symbol      (s_tdata[6:0]),
        .code_value  (s_tdata[38:7]),
        .code_length (s_tdata[44:39]),
        .q_stat      (q_stat),
        .push        (q_push),
        .job         (q_in)
    );

    hpk_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .status    (q_stat)
    );

    hpk_back #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .LEN_W         (LEN_W),
        .JOB_W         (JOB_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .job      (q_out),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
